// ----- rtl/u8sd_pkg.sv -----
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// Transaction structs for the byte and character channels, saturation limits.
// No dependencies.
package u8sd_pkg;

    // Default text length limit, in bytes (33 bits holds up to 2^32).
    localparam logic [32:0] MAX_TEXT_BYTES_DEF = 33'd65536;

    localparam logic [16:0] POS_SAT  = 17'h1FFFF;
    localparam logic [16:0] CNT_SAT  = 17'h10000;
    localparam logic [15:0] OFF_SAT  = 16'hFFFF;
    localparam logic [20:0] CP_MAX   = 21'h10FFFF;
    localparam logic [20:0] MIN_LEN2 = 21'h00080;
    localparam logic [20:0] MIN_LEN3 = 21'h00800;
    localparam logic [20:0] MIN_LEN4 = 21'h10000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        has_char;
        logic [20:0] code_point;
        logic [2:0]  seq_length;
        logic [15:0] start_offset;
        logic [16:0] char_total;
        logic        end_of_text;
    } out_item_t;

endpackage

// ----- rtl/utf8_stream_decoder_core.sv -----
// utf8_stream_decoder_core: byte-serial UTF-8 decoder, top level.
// Depends on u8sd_pkg (transaction structs, limits).
//
// Usage
//   Byte channel (byte_valid / byte_stall / byte_item): one transaction carries
//   one raw text byte and a last-byte flag. It is accepted on a rising edge with
//   byte_valid high and byte_stall low.
//   Char channel (char_valid / char_stall / char_item): at most one transaction
//   per accepted byte: a decoded character, an end-of-text marker, or both.
//   Bytes that only extend a sequence or are skipped produce nothing.
//   The result of an accepted byte is registered into char_item, or into the
//   skid register while char_item is held. Throughput: one byte per cycle while
//   byte_stall is low; the decode is a single pass of shift/mask/compare logic
//   from the byte port into the state and result registers.
//   Stall: the result register is backed by a one-entry skid register, so a
//   byte is still accepted while a finished result waits. byte_stall rises
//   only when both hold results, and is a pure register output.
//   Reset (rst_n low, asynchronous): all decoder state, counters and both
//   result slots clear; the next byte starts a new text at offset 0.
//   A NUL byte ends the text; later bytes are swallowed until the last byte.
//   A byte at offset MAX_TEXT_BYTES-1 is treated as a last byte.
module utf8_stream_decoder_core #(
    parameter logic [32:0] MAX_TEXT_BYTES = u8sd_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  u8sd_pkg::in_item_t   byte_item,
    output logic                 char_valid,
    input  logic                 char_stall,
    output u8sd_pkg::out_item_t  char_item
);
    import u8sd_pkg::*;

    // Last offset of a text; compared against the 17-bit position widened.
    localparam logic [32:0] LIMIT = MAX_TEXT_BYTES - 33'd1;

    // Decoder state
    logic [1:0]  pending_count_reg,  pending_count_next;
    logic [20:0] partial_code_reg,   partial_code_next;
    logic [2:0]  current_length_reg, current_length_next;
    logic [15:0] lead_offset_reg,    lead_offset_next;
    logic [16:0] byte_position_reg,  byte_position_next;
    logic [16:0] char_counter_reg,   char_counter_next;
    logic        stopped_flag_reg,   stopped_flag_next;

    // Result register plus skid slot
    logic        char_valid_reg;
    out_item_t   char_item_reg;
    logic        skid_valid_reg;
    out_item_t   skid_item_reg;

    logic        acc;
    logic        emit;
    logic        eff_last;
    out_item_t   res;

    // Combinational scratch
    logic [7:0]  b;
    logic        got;
    logic        lead;
    logic [2:0]  n;
    logic [15:0] cur_off;
    logic [20:0] shifted;
    logic [20:0] lo;

    assign acc        = byte_valid && !byte_stall;
    assign byte_stall = skid_valid_reg;
    assign char_valid = char_valid_reg;
    assign char_item  = char_item_reg;

    // ---------------------------------------------------------------
    // Single-pass decode of one byte
    // ---------------------------------------------------------------
    always_comb
    begin
        b        = byte_item.text_byte;
        eff_last = byte_item.last_byte || ({16'd0, byte_position_reg} >= LIMIT);
        cur_off  = byte_position_reg[16] ? OFF_SAT : byte_position_reg[15:0];
        got      = 1'b0;
        lead     = 1'b1;
        n        = 3'd0;
        shifted  = {partial_code_reg[14:0], b[5:0]};
        lo       = (current_length_reg == 3'd2) ? MIN_LEN2 :
                   (current_length_reg == 3'd3) ? MIN_LEN3 : MIN_LEN4;

        res.has_char     = 1'b0;
        res.code_point   = '0;
        res.seq_length   = '0;
        res.start_offset = cur_off;
        res.char_total   = '0;
        res.end_of_text  = 1'b0;

        pending_count_next  = pending_count_reg;
        partial_code_next   = partial_code_reg;
        current_length_next = current_length_reg;
        lead_offset_next    = lead_offset_reg;
        char_counter_next   = char_counter_reg;
        stopped_flag_next   = stopped_flag_reg;
        byte_position_next  = (byte_position_reg == POS_SAT) ? byte_position_reg
                                                             : byte_position_reg + 17'd1;
        emit = 1'b0;

        if (stopped_flag_reg)
        begin
            // swallowed bytes; only the last byte matters (clears below)
            emit = 1'b0;
        end
        else
        begin
            if (b == 8'h00)
            begin
                pending_count_next  = '0;
                partial_code_next   = '0;
                current_length_next = '0;
                stopped_flag_next   = 1'b1;
            end
            else
            begin
                if (pending_count_reg != 2'd0)
                begin
                    if (b[7:6] == 2'b10)
                    begin
                        lead               = 1'b0;
                        partial_code_next  = shifted;
                        pending_count_next = pending_count_reg - 2'd1;
                        if (pending_count_reg == 2'd1)
                        begin
                            // sequence complete: drop overlong / out of range
                            if (shifted >= lo && shifted <= CP_MAX)
                            begin
                                got              = 1'b1;
                                res.code_point   = shifted;
                                res.seq_length   = current_length_reg;
                                res.start_offset = lead_offset_reg;
                            end
                            partial_code_next   = '0;
                            current_length_next = '0;
                        end
                    end
                    else
                    begin
                        // broken sequence: drop it, byte is reread as a lead
                        pending_count_next  = '0;
                        partial_code_next   = '0;
                        current_length_next = '0;
                    end
                end

                if (lead)
                begin
                    if (b < 8'h80)
                    begin
                        got            = 1'b1;
                        res.code_point = {13'd0, b};
                        res.seq_length = 3'd1;
                    end
                    else if (b inside {[8'hC2:8'hDF]})
                    begin
                        n = 3'd2;
                    end
                    else if (b inside {[8'hE0:8'hEF]})
                    begin
                        n = 3'd3;
                    end
                    else if (b inside {[8'hF0:8'hF4]})
                    begin
                        n = 3'd4;
                    end

                    if (n != 3'd0)
                    begin
                        partial_code_next   = {13'd0, b & (8'hFF >> n)};
                        pending_count_next  = 2'(n - 3'd1);
                        current_length_next = n;
                        lead_offset_next    = cur_off;
                    end
                end
            end

            if (got && char_counter_reg < CNT_SAT)
                char_counter_next = char_counter_reg + 17'd1;

            emit = got || (b == 8'h00) || eff_last;
        end

        res.has_char    = got;
        res.char_total  = char_counter_next;
        res.end_of_text = (b == 8'h00) || eff_last;

        if (eff_last)
        begin
            pending_count_next  = '0;
            partial_code_next   = '0;
            current_length_next = '0;
            lead_offset_next    = '0;
            byte_position_next  = '0;
            char_counter_next   = '0;
            stopped_flag_next   = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg  <= '0;
            partial_code_reg   <= '0;
            current_length_reg <= '0;
            lead_offset_reg    <= '0;
            byte_position_reg  <= '0;
            char_counter_reg   <= '0;
            stopped_flag_reg   <= 1'b0;
        end
        else if (acc)
        begin
            pending_count_reg  <= pending_count_next;
            partial_code_reg   <= partial_code_next;
            current_length_reg <= current_length_next;
            lead_offset_reg    <= lead_offset_next;
            byte_position_reg  <= byte_position_next;
            char_counter_reg   <= char_counter_next;
            stopped_flag_reg   <= stopped_flag_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register and skid slot: valid flags
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!char_valid_reg || !char_stall)
        begin
            // output slot frees up this cycle
            if (skid_valid_reg)
            begin
                char_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                char_valid_reg <= acc && emit;
            end
        end
        else if (acc && emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!char_valid_reg || !char_stall)
        begin
            if (skid_valid_reg)
                char_item_reg <= skid_item_reg;
            else if (acc && emit)
                char_item_reg <= res;
        end
        else if (acc && emit)
        begin
            skid_item_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    // skid slot only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> char_valid_reg)
        else $error("skid slot full while result slot empty");

    // a character result is always within CP_MAX and has a length
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_item.has_char) |->
            (char_item.seq_length != 3'd0 && char_item.code_point <= CP_MAX))
        else $error("character result out of range");

    // end of text restarts the decoder
    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && eff_last) |=>
            (byte_position_reg == '0 && stopped_flag_reg == 1'b0
             && pending_count_reg == '0))
        else $error("state not cleared after end of text");
`endif

endmodule
